@@ design/mfma_pkg.sv @@
package mfma_pkg;

    // Field widths fixed by the frame layout
    localparam int ID_W      = 11;
    localparam int BYTE_W    = 8;
    localparam int ENC_W     = 16;
    localparam int DPC_W     = 24;
    localparam int ANGLE_W   = 48;
    // Widest angle sum before saturation (largest count width plus scale headroom)
    localparam int WIDE_W    = 57;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ID      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAT_LIM  = 8'd3;

    localparam logic [ID_W-1:0]   RST_MOTOR_ID      = 11'd517;
    localparam logic [DPC_W-1:0]  RST_DEG_PER_COUNT = 24'd737280;
    localparam logic [BYTE_W-1:0] RST_TEMP_LIMIT    = 8'd80;
    localparam logic [15:0]       RST_OVERHEAT_LIM  = 16'd200;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte3;
        logic [BYTE_W-1:0] byte4;
        logic [BYTE_W-1:0] byte5;
        logic [BYTE_W-1:0] byte6;
    } t_req;

    typedef struct packed {
        logic                      matched;
        logic [ENC_W-1:0]          encoder_raw;
        logic signed [15:0]        speed;
        logic signed [15:0]        current;
        logic [BYTE_W-1:0]         temperature;
        logic signed [ANGLE_W-1:0] angle_q8;
        logic                      over_temperature;
    } t_rsp;

    // Load strobes for the two scaling stages
    typedef struct packed {
        logic load_c;
        logic load_d;
    } t_stage_en;

endpackage

@@ design/mfma_track.sv @@
module mfma_track
    import mfma_pkg::*;
#(
    parameter int ENCODER_COUNTS = 8192,
    parameter int SUM_BITS       = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  t_req                       i_req,
    input  logic [ID_W-1:0]            i_motor_id,
    input  logic [BYTE_W-1:0]          i_temp_limit,
    input  logic [15:0]                i_overheat_limit,
    output t_rsp                       o_rsp,
    output logic signed [SUM_BITS-1:0] o_count_sum
);

    localparam logic signed [17:0] ENC_SPAN = 18'(ENCODER_COUNTS);
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic                       r_started;
    logic [ENC_W-1:0]           r_prev;
    logic signed [SUM_BITS-1:0] r_sum;
    logic [15:0]                r_streak;
    logic                       r_flag;

    logic [15:0]                n_streak;
    logic                       n_flag;
    logic signed [SUM_BITS-1:0] n_sum;

    logic                       matched;
    logic [ENC_W-1:0]           enc;
    logic [ENC_W-1:0]           prev_eff;
    logic [16:0]                streak_inc;
    logic signed [17:0]         diff;
    logic signed [17:0]         wrapped;
    logic signed [17:0]         step;
    logic [17:0]                abs_d;
    logic [17:0]                abs_w;
    logic signed [SUM_BITS-1:0] sum_base;
    logic signed [SUM_BITS:0]   sum_ext;

    t_rsp                       r_rsp;
    logic signed [SUM_BITS-1:0] r_cs;

    always_comb begin
        matched    = (i_req.frame_id == i_motor_id);
        enc        = {i_req.byte0, i_req.byte1};

        // overheat streak; flag is sticky
        streak_inc = 17'(r_streak) + 17'd1;
        n_streak   = 16'd0;
        n_flag     = r_flag;
        if (i_req.byte6 > i_temp_limit) begin
            if (streak_inc > {1'b0, i_overheat_limit}) begin
                n_flag = 1'b1;
            end else begin
                n_streak = streak_inc[15:0];
            end
        end

        // first match seeds previous position and zeroes the sum
        prev_eff = r_started ? r_prev : enc;
        sum_base = r_started ? r_sum : '0;

        diff = $signed({2'b00, enc}) - $signed({2'b00, prev_eff});
        if (enc < prev_eff) begin
            wrapped = diff + ENC_SPAN;
        end else if (enc > prev_eff) begin
            wrapped = diff - ENC_SPAN;
        end else begin
            wrapped = 18'sd0;
        end
        abs_d = diff[17]    ? 18'(-diff)    : 18'(diff);
        abs_w = wrapped[17] ? 18'(-wrapped) : 18'(wrapped);
        // ties go to the wrapped step
        step  = (abs_w > abs_d) ? diff : wrapped;

        sum_ext = (SUM_BITS+1)'(sum_base) + (SUM_BITS+1)'(step);
        if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
            n_sum = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = sum_ext[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_prev    <= '0;
            r_sum     <= '0;
            r_streak  <= '0;
            r_flag    <= 1'b0;
        end else if (i_step && matched) begin
            r_started <= 1'b1;
            r_prev    <= enc;
            r_sum     <= n_sum;
            r_streak  <= n_streak;
            r_flag    <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (matched) begin
                r_rsp.matched          <= 1'b1;
                r_rsp.encoder_raw      <= enc;
                r_rsp.speed            <= $signed({i_req.byte2, i_req.byte3});
                r_rsp.current          <= $signed({i_req.byte4, i_req.byte5});
                r_rsp.temperature      <= i_req.byte6;
                r_rsp.angle_q8         <= '0;
                r_rsp.over_temperature <= n_flag;
                r_cs                   <= n_sum;
            end else begin
                r_rsp <= '0;
                r_cs  <= '0;
            end
        end
    end

    assign o_rsp       = r_rsp;
    assign o_count_sum = r_cs;

endmodule

@@ design/mfma_scale.sv @@
module mfma_scale
    import mfma_pkg::*;
#(
    parameter int SUM_BITS = 40
) (
    input  logic                       i_clk,
    input  t_stage_en                  i_en,
    input  t_rsp                       i_rsp,
    input  logic signed [SUM_BITS-1:0] i_count_sum,
    input  logic [DPC_W-1:0]           i_deg_per_count,
    output t_rsp                       o_rsp
);

    // count = hi * 2^16 + lo, so floor(count * dpc / 2^16) = hi*dpc + (lo*dpc >> 16)
    localparam int HI_W  = SUM_BITS - 16;
    localparam int PHI_W = SUM_BITS + 8;
    localparam int PLO_W = 16 + DPC_W;

    localparam logic signed [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    logic signed [HI_W-1:0]   cs_hi;
    logic [15:0]              cs_lo;
    logic signed [DPC_W:0]    dpc_s;
    logic signed [PHI_W-1:0]  n_p_hi;
    logic [PLO_W-1:0]         n_p_lo;
    logic signed [PHI_W-1:0]  r_p_hi;
    logic [PLO_W-1:0]         r_p_lo;
    t_rsp                     r_rsp_c;
    t_rsp                     r_rsp_d;
    t_rsp                     n_rsp_d;
    logic signed [WIDE_W-1:0] wide;
    logic [WIDE_W-ANGLE_W:0]  top_bits;
    logic signed [ANGLE_W-1:0] angle;

    always_comb begin
        cs_hi  = i_count_sum[SUM_BITS-1:16];
        cs_lo  = i_count_sum[15:0];
        dpc_s  = $signed({1'b0, i_deg_per_count});
        n_p_hi = PHI_W'(cs_hi) * PHI_W'(dpc_s);
        n_p_lo = PLO_W'(cs_lo) * PLO_W'(i_deg_per_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_c) begin
            r_p_hi  <= n_p_hi;
            r_p_lo  <= n_p_lo;
            r_rsp_c <= i_rsp;
        end
    end

    always_comb begin
        wide     = WIDE_W'(r_p_hi) + WIDE_W'($signed({1'b0, r_p_lo[PLO_W-1:16]}));
        top_bits = wide[WIDE_W-1:ANGLE_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            angle = wide[ANGLE_W-1:0];
        end else begin
            angle = wide[WIDE_W-1] ? ANG_MIN : ANG_MAX;
        end
        n_rsp_d          = r_rsp_c;
        n_rsp_d.angle_q8 = angle;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_d) begin
            r_rsp_d <= n_rsp_d;
        end
    end

    assign o_rsp = r_rsp_d;

endmodule

@@ design/motor_feedback_multiturn_angle_core.sv @@
// Motor feedback multi-turn angle core.
// Request channel (i_req_valid/o_req_ready, i_req): one received feedback frame,
//   identifier plus seven payload bytes. One request is taken per cycle while o_req_ready is high.
// Response channel (o_rsp_valid/i_rsp_ready, o_rsp): exactly one response per
//   request, in order. Non-matching identifiers give an all-zero response.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): always ready;
//   the user must write it only while the core holds no request in flight (unchecked).
// Path: a taken request passes through four registers - input, unwrap and count
//   update, scale multipliers, angle add/saturate - before its response is valid.
// Throughput: 1 request per cycle while i_rsp_ready does not stall the pipe. The count
//   accumulator closes its loop through a single register; the scaling multiply is a feed-forward pipe.
// Stall: each stage holds while the one after it is full and not draining, so
//   bubbles are squeezed out and up to four requests sit in the pipe while the
//   receiver holds i_rsp_ready low.
// Reset (i_rst_n, synchronous): empties the pipe, clears the unwrap/overheat
//   state and reloads config defaults.
module motor_feedback_multiturn_angle_core
    import mfma_pkg::*;
#(
    parameter int ENCODER_COUNTS = 8192,
    parameter int SUM_BITS       = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // config registers
    logic [ID_W-1:0]   r_motor_id;
    logic [DPC_W-1:0]  r_deg_per_count;
    logic [BYTE_W-1:0] r_temp_limit;
    logic [15:0]       r_overheat_lim;

    // stage valids: A input, B tracked, C products, D output
    logic r_va, r_vb, r_vc, r_vd;
    logic free_a, free_b, free_c, free_d;

    t_req                       r_req;
    t_rsp                       trk_rsp;
    logic signed [SUM_BITS-1:0] trk_cs;
    t_stage_en                  stage_en;
    logic                       step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id      <= RST_MOTOR_ID;
            r_deg_per_count <= RST_DEG_PER_COUNT;
            r_temp_limit    <= RST_TEMP_LIMIT;
            r_overheat_lim  <= RST_OVERHEAT_LIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MOTOR_ID:      r_motor_id      <= i_cfg_data[ID_W-1:0];
                REG_DEG_PER_COUNT: r_deg_per_count <= i_cfg_data[DPC_W-1:0];
                REG_TEMP_LIMIT:    r_temp_limit    <= i_cfg_data[BYTE_W-1:0];
                REG_OVERHEAT_LIM:  r_overheat_lim  <= i_cfg_data[15:0];
                default: ;         // unmapped index, ignored
            endcase
        end
    end

    // a stage can load when empty or when its contents move on
    always_comb begin
        free_d = !r_vd || i_rsp_ready;
        free_c = !r_vc || free_d;
        free_b = !r_vb || free_c;
        free_a = !r_va || free_b;
        step            = r_va && free_b;
        stage_en.load_c = r_vb && free_c;
        stage_en.load_d = r_vc && free_d;
    end

    assign o_req_ready = free_a;
    assign o_rsp_valid = r_vd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (free_a) begin
                r_va <= i_req_valid;
            end
            if (free_b) begin
                r_vb <= r_va;
            end
            if (free_c) begin
                r_vc <= r_vb;
            end
            if (free_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && free_a) begin
            r_req <= i_req;
        end
    end

    mfma_track #(
        .ENCODER_COUNTS (ENCODER_COUNTS),
        .SUM_BITS       (SUM_BITS)
    ) u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_req            (r_req),
        .i_motor_id       (r_motor_id),
        .i_temp_limit     (r_temp_limit),
        .i_overheat_limit (r_overheat_lim),
        .o_rsp            (trk_rsp),
        .o_count_sum      (trk_cs)
    );

    mfma_scale #(
        .SUM_BITS (SUM_BITS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_en            (stage_en),
        .i_rsp           (trk_rsp),
        .i_count_sum     (trk_cs),
        .i_deg_per_count (r_deg_per_count),
        .o_rsp           (o_rsp)
    );

endmodule
